FILE: rtl/qrs_pkg.sv
// qrs_pkg: shared types and constants for the quadratic root solver
// no dependencies; compiled first
package qrs_pkg;

    // width of the tolerance register
    localparam int TOL_WIDTH = 31;

    // tolerance after reset, in lsbs
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 31'd1;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;

    // result status codes
    localparam logic [1:0] ST_NONE = 2'd0;
    localparam logic [1:0] ST_ONE  = 2'd1;
    localparam logic [1:0] ST_TWO  = 2'd2;
    localparam logic [1:0] ST_ALL  = 2'd3;

    // classification made by the front
    typedef enum logic [1:0] {
        CLS_ALL,
        CLS_NONE,
        CLS_LINEAR,
        CLS_QUAD
    } cls_t;

endpackage

FILE: rtl/qrs_if.sv
// qrs_if: valid/ready channel interfaces for coefficients, roots and config
// depends on qrs_pkg
interface qrs_coef_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] coef_a;
    logic signed [W-1:0] coef_b;
    logic signed [W-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrs_root_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic [1:0]          root_status;
    logic signed [W-1:0] root_first;
    logic signed [W-1:0] root_second;
    logic                saturated;

    modport source (output valid, output root_status, output root_first,
                    output root_second, output saturated, input ready);
    modport sink   (input valid, input root_status, input root_first,
                    input root_second, input saturated, output ready);
endinterface

interface qrs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [qrs_pkg::TOL_WIDTH-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/qrs_front.sv
// qrs_front: accepts coefficient words, forms the discriminant and classifies
// depends on qrs_pkg and qrs_if
module qrs_front #(
    parameter int COEF_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    qrs_coef_if.sink              coef,
    input  logic                  room,
    output logic                  push,
    output qrs_pkg::cls_t         cls,
    output logic [2*COEF_WIDTH:0] dr,
    output logic                  bneg,
    output logic [COEF_WIDTH-1:0] nmag,
    output logic [COEF_WIDTH:0]   den,
    output logic                  dneg
);
    localparam int W = COEF_WIDTH;

    logic en;

    // stage 1: sign and magnitude
    logic         v1_reg;
    logic         an1_reg, bn1_reg, cn1_reg;
    logic [W-1:0] am1_reg, bm1_reg, cm1_reg;

    // stage 2: products
    logic         v2_reg;
    logic         an2_reg, bn2_reg, cn2_reg;
    logic [W-1:0] am2_reg, bm2_reg, cm2_reg;
    logic [2*W-1:0] b2_reg, ac_reg;

    // stage 3: classified word
    logic            v3_reg;
    qrs_pkg::cls_t   cls_reg;
    logic [2*W:0]    dr_reg;
    logic            bneg_reg, dneg_reg;
    logic [W-1:0]    nmag_reg;
    logic [W:0]      den_reg;

    logic signed [2*W+2:0] d_next;
    logic [2*W+2:0]        b2_ext, ac4_ext;
    qrs_pkg::cls_t         cls_next;

    // the whole front moves only when the queue has room for all in flight
    assign en         = room;
    assign coef.ready = room;
    assign push       = en && v3_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= coef.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an1_reg <= coef.coef_a[W-1];
            bn1_reg <= coef.coef_b[W-1];
            cn1_reg <= coef.coef_c[W-1];
            am1_reg <= coef.coef_a[W-1] ? W'(-coef.coef_a) : W'(coef.coef_a);
            bm1_reg <= coef.coef_b[W-1] ? W'(-coef.coef_b) : W'(coef.coef_b);
            cm1_reg <= coef.coef_c[W-1] ? W'(-coef.coef_c) : W'(coef.coef_c);
        end
    end

    // stage 2 payload: b squared and a times c
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            an2_reg <= an1_reg;
            bn2_reg <= bn1_reg;
            cn2_reg <= cn1_reg;
            am2_reg <= am1_reg;
            bm2_reg <= bm1_reg;
            cm2_reg <= cm1_reg;
            b2_reg  <= (2*W)'(bm1_reg) * (2*W)'(bm1_reg);
            ac_reg  <= (2*W)'(am1_reg) * (2*W)'(cm1_reg);
        end
    end

    // discriminant and class
    always_comb
    begin
        b2_ext  = (2*W+3)'(b2_reg);
        ac4_ext = {1'b0, ac_reg, 2'b00};
        if (an2_reg == cn2_reg)
            d_next = signed'(b2_ext - ac4_ext);
        else
            d_next = signed'(b2_ext + ac4_ext);

        if (am2_reg == '0)
        begin
            if (bm2_reg == '0)
                cls_next = (cm2_reg == '0) ? qrs_pkg::CLS_ALL : qrs_pkg::CLS_NONE;
            else
                cls_next = qrs_pkg::CLS_LINEAR;
        end
        else if (d_next[2*W+2])
            cls_next = qrs_pkg::CLS_NONE;
        else
            cls_next = qrs_pkg::CLS_QUAD;
    end

    // stage 3 payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_reg  <= cls_next;
            dr_reg   <= d_next[2*W:0];
            bneg_reg <= bn2_reg;
            if (am2_reg == '0)
            begin
                nmag_reg <= cm2_reg;
                den_reg  <= {1'b0, bm2_reg};
                dneg_reg <= (cn2_reg == bn2_reg);
            end
            else
            begin
                nmag_reg <= bm2_reg;
                den_reg  <= {am2_reg, 1'b0};
                dneg_reg <= an2_reg;
            end
        end
    end

    assign cls  = cls_reg;
    assign dr   = dr_reg;
    assign bneg = bneg_reg;
    assign nmag = nmag_reg;
    assign den  = den_reg;
    assign dneg = dneg_reg;

endmodule

FILE: rtl/qrs_queue.sv
// qrs_queue: short fifo that decouples the front from the back
// depends on qrs_pkg
module qrs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             room,
    input  logic             pop_en,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);
    localparam int AW = qrs_pkg::QUEUE_AW;

    logic [WIDTH-1:0] mem [0:qrs_pkg::QUEUE_DEPTH-1];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [AW:0]      count_reg, count_next;
    logic             rd_valid_reg;
    logic [WIDTH-1:0] rd_data_reg;
    logic             pop;

    // room for the words the front may still have in flight
    assign room = count_reg <= (AW+1)'(qrs_pkg::QUEUE_DEPTH - 3);
    assign pop  = pop_en && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (pop_en)
                rd_valid_reg <= (count_reg != '0);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= wr_data;
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (pop)
            rd_data_reg <= mem[rptr_reg];
    end

    assign rd_valid = rd_valid_reg;
    assign rd_data  = rd_data_reg;

endmodule

FILE: rtl/qrs_back.sv
// qrs_back: pipelined square root, two dividers, tolerance test and clipping
// depends on qrs_pkg and qrs_if
module qrs_back #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          adv,
    input  logic                          in_valid,
    input  qrs_pkg::cls_t                 cls,
    input  logic [2*COEF_WIDTH:0]         dr,
    input  logic                          bneg,
    input  logic [COEF_WIDTH-1:0]         nmag,
    input  logic [COEF_WIDTH:0]           den,
    input  logic                          dneg,
    input  logic [qrs_pkg::TOL_WIDTH-1:0] tol,
    qrs_root_if.source                    root
);
    localparam int W    = COEF_WIDTH;
    localparam int SQ   = W + 1;
    localparam int RW   = SQ + 2;
    localparam int RADW = 2 * SQ;
    localparam int NW   = W + 2 + FRAC_BITS;
    localparam int DW   = W + 1;
    localparam int CW   = (NW > qrs_pkg::TOL_WIDTH) ? NW : qrs_pkg::TOL_WIDTH;

    typedef struct packed {
        qrs_pkg::cls_t cls;
        logic          bneg;
        logic [W-1:0]  nmag;
        logic [DW-1:0] den;
        logic          dneg;
    } carry_t;

    // one root bit per step
    function automatic logic [RW+SQ-1:0] sq_step(input logic [RW-1:0] rem,
                                                 input logic [SQ-1:0] rt,
                                                 input logic [1:0]    bits);
        logic [RW+1:0] t;
        logic [RW+1:0] trial;
        logic          ge;
        t     = {rem, bits};
        trial = {2'b00, rt, 2'b01};
        ge    = (t >= trial);
        return {(ge ? RW'(t - trial) : RW'(t)), rt[SQ-2:0], ge};
    endfunction

    // one quotient bit per step, quotient shifts in behind the numerator
    function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] rem,
                                                  input logic [NW-1:0] x,
                                                  input logic [DW-1:0] d);
        logic [DW:0] t;
        logic        ge;
        t  = {rem, x[NW-1]};
        ge = (t >= {1'b0, d});
        return {(ge ? DW'(t - {1'b0, d}) : DW'(t)), x[NW-2:0], ge};
    endfunction

    // saturate a sign and magnitude quotient to the coefficient range
    function automatic logic [W:0] clip(input logic neg, input logic [NW-1:0] mag);
        logic [NW-1:0] lim;
        lim = NW'(1) << (W - 1);
        if (neg)
        begin
            if (mag > lim)
                return {1'b1, 1'b1, {(W-1){1'b0}}};
            return {1'b0, W'(-mag)};
        end
        if (mag >= lim)
            return {1'b1, 1'b0, {(W-1){1'b1}}};
        return {1'b0, W'(mag)};
    endfunction

    // square root stages
    logic          sq_v    [1:SQ];
    carry_t        sq_c    [1:SQ];
    logic [RADW-1:0] sq_rad [1:SQ];
    logic [RW-1:0] sq_rem  [1:SQ];
    logic [SQ-1:0] sq_root [1:SQ];

    // numerator stage
    logic          n_v_reg;
    qrs_pkg::cls_t n_cls_reg;
    logic [DW-1:0] n_den_reg;
    logic [NW-1:0] n_x1_reg, n_x2_reg;
    logic          n_neg1_reg, n_neg2_reg;

    // divider stages
    logic          dv_v    [1:NW];
    qrs_pkg::cls_t dv_cls  [1:NW];
    logic [DW-1:0] dv_den  [1:NW];
    logic [NW-1:0] dv_x1   [1:NW];
    logic [NW-1:0] dv_x2   [1:NW];
    logic [DW-1:0] dv_r1   [1:NW];
    logic [DW-1:0] dv_r2   [1:NW];
    logic          dv_neg1 [1:NW];
    logic          dv_neg2 [1:NW];

    // end stage
    logic          e_v_reg;
    qrs_pkg::cls_t e_cls_reg;
    logic [NW-1:0] e_diff_reg;
    logic [W-1:0]  e_r1_reg, e_r2_reg;
    logic          e_s1_reg, e_s2_reg;

    // output register
    logic          out_v_reg;
    logic [1:0]    status_reg;
    logic [W-1:0]  first_reg, second_reg;
    logic          sat_reg;

    // the back moves as one when the output register can take a word
    assign adv = !out_v_reg || root.ready;

    // square root pipeline
    for (genvar k = 0; k < SQ; k++)
    begin : g_sq
        logic            v_in;
        carry_t          c_in;
        logic [RADW-1:0] rad_in;
        logic [RW-1:0]   rem_in;
        logic [SQ-1:0]   root_in;
        logic [RW+SQ-1:0] step;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign c_in    = '{cls: cls, bneg: bneg, nmag: nmag, den: den, dneg: dneg};
            assign rad_in  = {1'b0, dr};
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign v_in    = sq_v[k];
            assign c_in    = sq_c[k];
            assign rad_in  = sq_rad[k];
            assign rem_in  = sq_rem[k];
            assign root_in = sq_root[k];
        end

        assign step = sq_step(rem_in, root_in, rad_in[RADW-1 -: 2]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v[k+1] <= 1'b0;
            else if (adv)
                sq_v[k+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_c[k+1]    <= c_in;
                sq_rad[k+1]  <= rad_in << 2;
                sq_rem[k+1]  <= step[RW+SQ-1:SQ];
                sq_root[k+1] <= step[SQ-1:0];
            end
        end
    end

    // numerators -b plus and minus the root, or c for the linear case
    logic signed [W+2:0] nb, s_ext, n1, n2;
    logic [W+1:0]        m1, m2;
    logic                s1, s2;

    always_comb
    begin
        s_ext = signed'({2'b00, sq_root[SQ]});
        nb    = sq_c[SQ].bneg ? signed'((W+3)'(sq_c[SQ].nmag))
                              : -signed'((W+3)'(sq_c[SQ].nmag));
        n1    = nb + s_ext;
        n2    = nb - s_ext;
        if (sq_c[SQ].cls == qrs_pkg::CLS_LINEAR)
        begin
            m1 = (W+2)'(sq_c[SQ].nmag);
            s1 = 1'b0;
        end
        else
        begin
            s1 = n1[W+2];
            m1 = s1 ? (W+2)'(-n1) : n1[W+1:0];
        end
        s2 = n2[W+2];
        m2 = s2 ? (W+2)'(-n2) : n2[W+1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_v_reg <= 1'b0;
        else if (adv)
            n_v_reg <= sq_v[SQ];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_cls_reg  <= sq_c[SQ].cls;
            n_den_reg  <= sq_c[SQ].den;
            n_x1_reg   <= NW'(m1) << FRAC_BITS;
            n_x2_reg   <= NW'(m2) << FRAC_BITS;
            n_neg1_reg <= s1 ^ sq_c[SQ].dneg;
            n_neg2_reg <= s2 ^ sq_c[SQ].dneg;
        end
    end

    // divider pipeline, both branches share the denominator
    for (genvar k = 0; k < NW; k++)
    begin : g_dv
        logic          v_in;
        qrs_pkg::cls_t cls_in;
        logic [DW-1:0] den_in, r1_in, r2_in;
        logic [NW-1:0] x1_in, x2_in;
        logic          neg1_in, neg2_in;
        logic [DW+NW-1:0] st1, st2;

        if (k == 0)
        begin : g_first
            assign v_in    = n_v_reg;
            assign cls_in  = n_cls_reg;
            assign den_in  = n_den_reg;
            assign x1_in   = n_x1_reg;
            assign x2_in   = n_x2_reg;
            assign r1_in   = '0;
            assign r2_in   = '0;
            assign neg1_in = n_neg1_reg;
            assign neg2_in = n_neg2_reg;
        end
        else
        begin : g_rest
            assign v_in    = dv_v[k];
            assign cls_in  = dv_cls[k];
            assign den_in  = dv_den[k];
            assign x1_in   = dv_x1[k];
            assign x2_in   = dv_x2[k];
            assign r1_in   = dv_r1[k];
            assign r2_in   = dv_r2[k];
            assign neg1_in = dv_neg1[k];
            assign neg2_in = dv_neg2[k];
        end

        assign st1 = div_step(r1_in, x1_in, den_in);
        assign st2 = div_step(r2_in, x2_in, den_in);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v[k+1] <= 1'b0;
            else if (adv)
                dv_v[k+1] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_cls[k+1]  <= cls_in;
                dv_den[k+1]  <= den_in;
                dv_r1[k+1]   <= st1[DW+NW-1:NW];
                dv_x1[k+1]   <= st1[NW-1:0];
                dv_r2[k+1]   <= st2[DW+NW-1:NW];
                dv_x2[k+1]   <= st2[NW-1:0];
                dv_neg1[k+1] <= neg1_in;
                dv_neg2[k+1] <= neg2_in;
            end
        end
    end

    // absolute difference of the exact quotients and clipping
    logic signed [NW:0] d_sum;
    logic [NW-1:0]      d_abs;
    logic [W:0]         c1, c2;

    always_comb
    begin
        if (dv_neg1[NW] == dv_neg2[NW])
            d_sum = signed'((NW+1)'(dv_x1[NW]) - (NW+1)'(dv_x2[NW]));
        else
            d_sum = signed'((NW+1)'(dv_x1[NW]) + (NW+1)'(dv_x2[NW]));
        d_abs = d_sum[NW] ? NW'(-d_sum) : d_sum[NW-1:0];
        c1    = clip(dv_neg1[NW], dv_x1[NW]);
        c2    = clip(dv_neg2[NW], dv_x2[NW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else if (adv)
            e_v_reg <= dv_v[NW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_cls_reg  <= dv_cls[NW];
            e_diff_reg <= d_abs;
            e_s1_reg   <= c1[W];
            e_r1_reg   <= c1[W-1:0];
            e_s2_reg   <= c2[W];
            e_r2_reg   <= c2[W-1:0];
        end
    end

    // status selection into the output register
    logic       near;
    logic [1:0] status_next;
    logic [W-1:0] first_next, second_next;
    logic       sat_next;

    always_comb
    begin
        near        = CW'(e_diff_reg) < CW'(tol);
        status_next = qrs_pkg::ST_NONE;
        first_next  = '0;
        second_next = '0;
        sat_next    = 1'b0;
        case (e_cls_reg)
            qrs_pkg::CLS_ALL:
                status_next = qrs_pkg::ST_ALL;
            qrs_pkg::CLS_LINEAR:
            begin
                status_next = qrs_pkg::ST_ONE;
                first_next  = e_r1_reg;
                sat_next    = e_s1_reg;
            end
            qrs_pkg::CLS_QUAD:
            begin
                first_next = e_r1_reg;
                if (near)
                begin
                    status_next = qrs_pkg::ST_ONE;
                    sat_next    = e_s1_reg;
                end
                else
                begin
                    status_next = qrs_pkg::ST_TWO;
                    second_next = e_r2_reg;
                    sat_next    = e_s1_reg | e_s2_reg;
                end
            end
            default:
                status_next = qrs_pkg::ST_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= e_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= status_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            sat_reg    <= sat_next;
        end
    end

    assign root.valid       = out_v_reg;
    assign root.root_status = status_reg;
    assign root.root_first  = signed'(first_reg);
    assign root.root_second = signed'(second_reg);
    assign root.saturated   = sat_reg;

endmodule

FILE: rtl/quadratic_root_solver_unit.sv
// quadratic_root_solver_unit: top level of the fixed-point quadratic root solver
// depends on qrs_pkg, qrs_if, qrs_front, qrs_queue and qrs_back

// Takes one coefficient word (a, b, c in signed Q format) per clock and
// returns one root word per clock in steady state. The front decodes signs,
// forms b*b and 4*a*c and classifies the word in three stages; an eight-entry
// queue separates it from the back, which takes the square root one bit per
// stage (COEF_WIDTH+1 stages) and divides both branches one quotient bit per
// stage (COEF_WIDTH+2+FRAC_BITS stages), then applies the tolerance test and
// clipping. When the root port stalls the back holds and the front keeps
// accepting until the queue holds six words. The tolerance register is
// written through the cfg channel, always ready; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    qrs_coef_if.sink   coef,
    qrs_cfg_if.sink    cfg,
    qrs_root_if.source root
);
    localparam int W  = COEF_WIDTH;
    localparam int EW = 2 + (2*W+1) + 1 + W + (W+1) + 1;

    logic [qrs_pkg::TOL_WIDTH-1:0] tol_reg;

    logic            room, push, adv, q_valid;
    qrs_pkg::cls_t   f_cls;
    logic [2*W:0]    f_dr;
    logic            f_bneg, f_dneg;
    logic [W-1:0]    f_nmag;
    logic [W:0]      f_den;
    logic [EW-1:0]   q_wr, q_rd;

    // tolerance register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= qrs_pkg::TOL_RESET;
        else if (cfg.valid)
            tol_reg <= cfg.data;
    end

    qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .coef  (coef),
        .room  (room),
        .push  (push),
        .cls   (f_cls),
        .dr    (f_dr),
        .bneg  (f_bneg),
        .nmag  (f_nmag),
        .den   (f_den),
        .dneg  (f_dneg)
    );

    // pack the classified word for the queue
    assign q_wr = {f_cls, f_dr, f_bneg, f_nmag, f_den, f_dneg};

    qrs_queue #(.WIDTH(EW)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_data  (q_wr),
        .room     (room),
        .pop_en   (adv),
        .rd_valid (q_valid),
        .rd_data  (q_rd)
    );

    qrs_back #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (q_valid),
        .cls      (qrs_pkg::cls_t'(q_rd[EW-1 -: 2])),
        .dr       (q_rd[EW-3 -: 2*W+1]),
        .bneg     (q_rd[2*W+2]),
        .nmag     (q_rd[2*W+1 -: W]),
        .den      (q_rd[W+1 -: W+1]),
        .dneg     (q_rd[0]),
        .tol      (tol_reg),
        .root     (root)
    );

endmodule

FILE: rtl/qrs_checker.sv
// qrs_checker: port-level assertions for the quadratic root solver
// depends on qrs_pkg; bound to quadratic_root_solver_unit below
module qrs_checker #(
    parameter int W = 32
) (
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_ready,
    input logic [1:0]   status,
    input logic [W-1:0] first,
    input logic [W-1:0] second,
    input logic         sat
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first) && $stable(second)
                                    && $stable(status) && $stable(sat))
        else $error("result word changed while stalled");

    // no roots reported for none and every-x
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == qrs_pkg::ST_NONE || status == qrs_pkg::ST_ALL)
        |-> first == '0 && second == '0 && !sat)
        else $error("root fields set without a root");

    // single root leaves the second field clear
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == qrs_pkg::ST_ONE |-> second == '0)
        else $error("second root set for a single root");

    // saturation only comes with a reported root
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sat |-> status == qrs_pkg::ST_ONE || status == qrs_pkg::ST_TWO)
        else $error("saturation flagged without a root");

endmodule

bind quadratic_root_solver_unit qrs_checker #(.W(COEF_WIDTH)) u_qrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (root.valid),
    .out_ready (root.ready),
    .status    (root.root_status),
    .first     (root.root_first),
    .second    (root.root_second),
    .sat       (root.saturated)
);

FILE: verif/quadratic_root_solver_unit_tb.sv
// testbench for quadratic_root_solver_unit: random and directed coefficient words
// checked against an in-bench predictor; depends on qrs_pkg and qrs_if
`timescale 1ns / 1ps

module quadratic_root_solver_unit_tb;

    localparam int FB = 16;
    localparam int CW = 32;
    localparam int LATENCY = CW * 2 + FB + 10;
    localparam longint LIMIT = 600000;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } coef_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic               sat;
    } root_word_t;

    logic clk;
    logic rst_n;

    qrs_coef_if #(.W(32)) coef ();
    qrs_root_if #(.W(32)) root ();
    qrs_cfg_if            cfg ();

    quadratic_root_solver_unit u_top (
        .clk  (clk),
        .rst_n(rst_n),
        .coef (coef.sink),
        .cfg  (cfg.sink),
        .root (root.source)
    );

    coef_word_t      pending_words[$];
    root_word_t      expected_roots[$];
    logic [30:0]     tolerance;
    int              error_count = 0;
    longint          cycle_count = 0;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_cycles = 0;
    bit              hold_req = 1'b0;
    bit              hold_started = 1'b0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // clip an exact quotient to the 32-bit signed range
    function automatic logic signed [31:0] clip_root(input logic signed [127:0] q,
                                                     inout logic sat);
        if (q > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (q < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return q[31:0];
    endfunction

    // signed quotient truncated toward zero
    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                      input logic signed [127:0] d);
        logic [127:0] mn;
        logic [127:0] md;
        logic [127:0] mq;
        mn = n < 0 ? -n : n;
        md = d < 0 ? -d : d;
        mq = mn / md;
        return ((n < 0) != (d < 0)) ? -$signed(mq) : $signed(mq);
    endfunction

    // floor square root of a nonnegative 128-bit value
    function automatic logic [63:0] floor_sqrt(input logic [127:0] d);
        logic [63:0]  s;
        logic [63:0]  t;
        logic [127:0] sq;
        s = '0;
        for (int i = 63; i >= 0; i--)
        begin
            t = s | (64'd1 << i);
            sq = t * t;
            if (sq <= d)
                s = t;
        end
        return s;
    endfunction

    // roots of one coefficient word under the current tolerance
    function automatic root_word_t solve_roots(input coef_word_t w);
        root_word_t          r;
        logic signed [127:0] a, b, c, disc, s, q1, q2, diff;
        logic                sat;
        r = '0;
        sat = 1'b0;
        a = w.a;
        b = w.b;
        c = w.c;
        if (a == 0)
        begin
            if (b == 0)
                r.status = (c == 0) ? qrs_pkg::ST_ALL : qrs_pkg::ST_NONE;
            else
            begin
                r.first = clip_root(trunc_div(-(c <<< FB), b), sat);
                r.status = qrs_pkg::ST_ONE;
            end
        end
        else
        begin
            disc = b * b - 4 * a * c;
            if (disc >= 0)
            begin
                s = $signed({64'd0, floor_sqrt(disc)});
                q1 = trunc_div((-b + s) <<< FB, 2 * a);
                q2 = trunc_div((-b - s) <<< FB, 2 * a);
                diff = q1 - q2;
                if (diff < 0)
                    diff = -diff;
                r.first = clip_root(q1, sat);
                if (diff < $signed({97'd0, tolerance}))
                    r.status = qrs_pkg::ST_ONE;
                else
                begin
                    r.status = qrs_pkg::ST_TWO;
                    r.second = clip_root(q2, sat);
                end
            end
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 8) << 16;
            2: return -($urandom_range(0, 8) << 16);
            3: return $signed($urandom_range(0, 2047)) - 1024;
            4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $signed($urandom) >>> $urandom_range(0, 31);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // driver: offers queued coefficient words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef.valid  <= 1'b0;
            coef.coef_a <= '0;
            coef.coef_b <= '0;
            coef.coef_c <= '0;
        end
        else
        begin
            if (coef.valid && coef.ready)
            begin
                expected_roots.push_back(solve_roots({coef.coef_a, coef.coef_b,
                                                      coef.coef_c}));
                void'(pending_words.pop_front());
            end
            if (!coef.valid || coef.ready)
            begin
                if (pending_words.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    coef.valid  <= 1'b1;
                    coef.coef_a <= pending_words[0].a;
                    coef.coef_b <= pending_words[0].b;
                    coef.coef_c <= pending_words[0].c;
                end
                else
                    coef.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each root word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        root_word_t want;
        if (!rst_n)
            root.ready <= 1'b0;
        else
        begin
            if (root.valid && root.ready)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected word", root.root_first, '0);
                else
                begin
                    want = expected_roots.pop_front();
                    if (root.root_status !== want.status)
                        report_mismatch("status", root.root_status, want.status);
                    if (root.root_first !== want.first)
                        report_mismatch("first", root.root_first, want.first);
                    if (root.root_second !== want.second)
                        report_mismatch("second", root.root_second, want.second);
                    if (root.saturated !== want.sat)
                        report_mismatch("saturated", root.saturated, want.sat);
                end
            end
            root.ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_req && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_cycles  <= 300;
        end
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || coef.valid || expected_roots.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [30:0] value);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        tolerance = value;
        cfg.valid <= 1'b0;
    endtask

    task automatic add_word(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c);
        coef_word_t w;
        w.a = a;
        w.b = b;
        w.c = c;
        pending_words.push_back(w);
    endtask

    task automatic random_phase(input int count);
        logic [31:0] r1, r2;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                // build from chosen roots so that real roots are common
                r1 = $signed($urandom_range(0, 4095)) - 2048;
                r2 = $signed($urandom_range(0, 4095)) - 2048;
                add_word(32'sd1 <<< $urandom_range(8, 16),
                         -((r1 + r2) <<< $urandom_range(8, 16)), r1 * r2);
            end
            else
                add_word(rand_coef(), rand_coef(), rand_coef());
        end
    endtask

    initial
    begin
        tolerance = qrs_pkg::TOL_RESET;
        send_idle_pct = 7;
        recv_idle_pct = 79;
        cfg.valid = 1'b0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset tolerance
        add_word(0, 0, 0);
        add_word(0, 0, 32'h00010000);
        add_word(0, 32'h00010000, 32'h00020000);
        add_word(0, 1, 32'h7fffffff);
        add_word(0, 32'h80000000, 32'h80000000);
        add_word(32'h00010000, 0, 32'h00010000);
        add_word(32'h00010000, 32'hfffe0000, 32'h00010000);
        add_word(32'h00010000, 0, 32'hffff0000);
        add_word(32'h80000000, 32'h80000000, 32'h80000000);
        add_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        add_word(32'h80000000, 32'h7fffffff, 32'h7fffffff);
        add_word(1, 32'h7fffffff, 0);
        add_word(32'hffffffff, 32'h80000000, 32'h7fffffff);
        add_word(32'hffffffff, 32'hffffffff, 32'hffffffff);
        add_word(1, 32'h00030000, 1);
        wait_drained();

        // tolerance zero: a double root is reported twice
        write_tolerance(0);
        add_word(32'h00010000, 32'hfffe0000, 32'h00010000);
        random_phase(300);
        // long stall while the sender keeps offering
        hold_req = 1'b1;
        wait_drained();

        write_tolerance(31'h7fffffff);
        send_idle_pct = 79;
        recv_idle_pct = 7;
        random_phase(300);
        wait_drained();

        write_tolerance($urandom_range(2, 1 << 20));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(400);
        wait_drained();

        write_tolerance(1);
        random_phase(400);
        wait_drained();

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: quadratic_root_solver_unit.f
rtl/qrs_pkg.sv
rtl/qrs_if.sv
rtl/qrs_front.sv
rtl/qrs_queue.sv
rtl/qrs_back.sv
rtl/quadratic_root_solver_unit.sv
rtl/qrs_checker.sv
verif/quadratic_root_solver_unit_tb.sv
